FILE: src/csrl_pkg.sv
// Shared types and constants for the compressed sparse row element store.
// No dependencies; used by sparse_matrix_csr_lookup_top.
`timescale 1ns / 1ps

package csrl_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;

  localparam int MODE_W = 2;
  localparam int ROW_W  = 8;
  localparam int COL_W  = 16;
  localparam int VAL_W  = 32;
  localparam int RIU_W  = ROW_W + 1;
  localparam int ENT_W  = COL_W + VAL_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

endpackage

FILE: src/sparse_matrix_csr_lookup_top.sv
// Compressed sparse row element store: sorted insertion, element query and clear.
// Depends on csrl_pkg and on csrl_ram for the entry and row start memories.
// One request is processed at a time; the result is held in an output register.
// Load shifts the later entries up one entry per cycle, inserts the new one and
// increments the following row starts; query walks the entries of the row; clear
// sweeps the row start memory to zero, as is also done after reset.
`timescale 1ns / 1ps

module sparse_matrix_csr_lookup_top #(
  parameter int MAX_ENTRIES = csrl_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_ROWS    = csrl_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [csrl_pkg::MODE_W-1:0]         mode_i,
  input  logic [csrl_pkg::ROW_W-1:0]          row_i,
  input  logic [csrl_pkg::COL_W-1:0]          col_i,
  input  logic signed [csrl_pkg::VAL_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [csrl_pkg::VAL_W-1:0]   element_o,
  output logic                                found_o,
  output logic                                status_o
);

  localparam int EAW = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int RAW = $clog2(MAX_ROWS + 1);
  localparam int COLW = csrl_pkg::COL_W;
  localparam int VALW = csrl_pkg::VAL_W;
  localparam int RIUW = csrl_pkg::RIU_W;
  localparam int ENTW = csrl_pkg::ENT_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RS0, S_RS1, S_RS2, S_SHIFT, S_INS,
    S_INC_RD, S_INC, S_Q_WALK, S_RESP
  } state_e;

  state_e              state_q;
  csrl_pkg::mode_e     mode_q;
  logic [csrl_pkg::ROW_W-1:0] row_q;
  logic [COLW-1:0]     col_q;
  logic [VALW-1:0]     val_q;
  logic [CW-1:0]       count_q, start_q, end_q, p_q, k_q;
  logic [RIUW-1:0]     riu_q;
  logic [RAW-1:0]      a_q;
  logic                clr_resp_q;
  logic [VALW-1:0]     res_elem_q;
  logic                res_found_q, res_status_q;
  logic                out_valid_q;
  logic [VALW-1:0]     element_q;
  logic                found_q, status_q;

  logic            rs_we;
  logic [RAW-1:0]  rs_waddr, rs_raddr;
  logic [CW-1:0]   rs_wdata, rs_rdata;
  logic            ent_we;
  logic [EAW-1:0]  ent_waddr, ent_raddr;
  logic [ENTW-1:0] ent_wdata, ent_rdata;

  logic [COLW-1:0] rd_col;
  logic [VALW-1:0] rd_val;
  logic [CW-1:0]   p_m1, p_m2, k_p1, cnt_m1;
  logic [RAW-1:0]  r_idx, r_p1, a_p1;
  logic [RIUW-1:0] r_p1_riu;
  logic            move, row_in_range, in_acc, out_free;

  assign rd_col   = ent_rdata[ENTW-1:VALW];
  assign rd_val   = ent_rdata[VALW-1:0];
  assign p_m1     = p_q - CW'(1);
  assign p_m2     = p_q - CW'(2);
  assign k_p1     = k_q + CW'(1);
  assign cnt_m1   = count_q - CW'(1);
  assign r_idx    = RAW'(row_q);
  assign r_p1     = r_idx + RAW'(1);
  assign a_p1     = a_q + RAW'(1);
  assign r_p1_riu = {1'b0, row_q} + RIUW'(1);
  assign move     = (p_q > end_q) || (rd_col > col_q);
  assign row_in_range = 32'(row_i) < 32'(MAX_ROWS);
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;

  csrl_ram #(.Width(CW), .Depth(MAX_ROWS + 1)) u_row_start (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  csrl_ram #(.Width(ENTW), .Depth(MAX_ENTRIES)) u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    rs_we     = 1'b0;
    rs_waddr  = a_q;
    rs_wdata  = '0;
    rs_raddr  = r_idx;
    ent_we    = 1'b0;
    ent_waddr = p_q[EAW-1:0];
    ent_wdata = {col_q, val_q};
    ent_raddr = k_p1[EAW-1:0];
    case (state_q)
      S_CLR: begin
        rs_we = 1'b1;
      end
      S_RS1: begin
        rs_raddr = r_p1;
      end
      S_RS2: begin
        if (mode_q == csrl_pkg::MODE_LOAD) begin
          ent_raddr = cnt_m1[EAW-1:0];
        end else begin
          ent_raddr = start_q[EAW-1:0];
        end
      end
      S_SHIFT: begin
        ent_we    = 1'b1;
        ent_raddr = p_m2[EAW-1:0];
        if (move) begin
          ent_wdata = ent_rdata;
        end
      end
      S_INS: begin
        ent_we = 1'b1;
      end
      S_INC_RD: begin
        rs_raddr = r_p1;
      end
      S_INC: begin
        rs_we    = 1'b1;
        rs_wdata = rs_rdata + CW'(1);
        rs_raddr = a_p1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      mode_q       <= csrl_pkg::MODE_CLEAR;
      row_q        <= '0;
      col_q        <= '0;
      val_q        <= '0;
      count_q      <= '0;
      start_q      <= '0;
      end_q        <= '0;
      p_q          <= '0;
      k_q          <= '0;
      riu_q        <= '0;
      a_q          <= '0;
      clr_resp_q   <= 1'b0;
      res_elem_q   <= '0;
      res_found_q  <= 1'b0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
      element_q    <= '0;
      found_q      <= 1'b0;
      status_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          a_q <= a_p1;
          if (a_q == RAW'(MAX_ROWS)) begin
            count_q    <= '0;
            riu_q      <= '0;
            clr_resp_q <= 1'b0;
            state_q    <= clr_resp_q ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            mode_q       <= csrl_pkg::mode_e'(mode_i);
            row_q        <= row_i;
            col_q        <= col_i;
            val_q        <= value_i;
            res_elem_q   <= '0;
            res_found_q  <= 1'b0;
            res_status_q <= 1'b0;
            case (csrl_pkg::mode_e'(mode_i))
              csrl_pkg::MODE_CLEAR: begin
                a_q        <= '0;
                clr_resp_q <= 1'b1;
                state_q    <= S_CLR;
              end
              csrl_pkg::MODE_LOAD: begin
                if (count_q == CW'(MAX_ENTRIES)) begin
                  res_status_q <= 1'b1;
                  state_q      <= S_RESP;
                end else if (!row_in_range) begin
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_RS0;
                end
              end
              csrl_pkg::MODE_QUERY: begin
                if (!row_in_range || ({1'b0, row_i} >= riu_q)) begin
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_RS0;
                end
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_RS0: begin
          state_q <= S_RS1;
        end
        S_RS1: begin
          start_q <= rs_rdata;
          state_q <= S_RS2;
        end
        S_RS2: begin
          end_q <= rs_rdata;
          if (mode_q == csrl_pkg::MODE_LOAD) begin
            p_q     <= count_q;
            state_q <= (count_q > start_q) ? S_SHIFT : S_INS;
          end else begin
            k_q     <= start_q;
            state_q <= (start_q < rs_rdata) ? S_Q_WALK : S_RESP;
          end
        end
        S_SHIFT: begin
          if (move) begin
            p_q <= p_m1;
            if (!(p_m1 > start_q)) begin
              state_q <= S_INS;
            end
          end else begin
            state_q <= S_INC_RD;
          end
        end
        S_INS: begin
          state_q <= S_INC_RD;
        end
        S_INC_RD: begin
          count_q <= count_q + CW'(1);
          if (r_p1_riu > riu_q) begin
            riu_q <= r_p1_riu;
          end
          a_q     <= r_p1;
          state_q <= S_INC;
        end
        S_INC: begin
          a_q <= a_p1;
          if (a_q == RAW'(MAX_ROWS)) begin
            state_q <= S_RESP;
          end
        end
        S_Q_WALK: begin
          if (rd_col == col_q) begin
            res_found_q <= 1'b1;
            res_elem_q  <= rd_val;
            state_q     <= S_RESP;
          end else if (k_p1 < end_q) begin
            k_q <= k_p1;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            element_q   <= res_elem_q;
            found_q     <= res_found_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign found_o     = found_q;
  assign status_o    = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds the store depth");

  a_count_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((count_q == '0) == (riu_q == '0)))
    else $error("entry count and rows in use disagree on an empty store");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (p_q > start_q && p_q <= count_q))
    else $error("shift pointer outside the row being loaded");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_WALK) |-> (k_q >= start_q && k_q < end_q))
    else $error("query walk outside the requested row");

  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result presented without a completed request");

endmodule

FILE: src/csrl_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module csrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
